// ----- src/lcr_pkg.sv -----
// shared constants and types for the lattice coefficient rounding unit
package lcr_pkg;

    // default number of bits dropped by power2round
    localparam int DROP_BITS_DEF = 13;

    // scheme constants
    localparam int Q_MOD    = 8380417;
    localparam int GAMMA2   = 95232;
    localparam int ALPHA    = 2 * GAMMA2;
    localparam int HALF_Q   = (Q_MOD - 1) / 2;
    localparam int HIGH_MAX = 43;

    // rounding divide by alpha: ((a + 127) >> 7) * 11275 + 2^23, then >> 24
    localparam int RND_BIAS    = 127;
    localparam int RND_SHIFT   = 7;
    localparam int MUL_RECIP   = 11275;
    localparam int RECIP_SHIFT = 24;

    // field widths
    localparam int COEFF_W = 23;
    localparam int LIN_W   = 24;
    localparam int HIN_W   = 6;
    localparam int HIGH_W  = 10;
    localparam int LOW_W   = 18;
    localparam int HC_W    = 6;
    localparam int T_W     = 17;
    localparam int PROD_W  = 31;

    // stream bus widths
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 32;

    localparam int N_STAGES = 5;

    typedef enum logic [1:0] {
        MODE_P2R       = 2'd0,
        MODE_DECOMPOSE = 2'd1,
        MODE_MAKE_HINT = 2'd2,
        MODE_USE_HINT  = 2'd3
    } t_mode;

    // per-stage load enables from the pipeline control
    typedef struct packed {
        logic [N_STAGES-1:0] en;
    } t_pipe_ctl;

    // payload after stage 2
    typedef struct packed {
        t_mode               mode;
        logic [COEFF_W-1:0]  coeff;
        logic                hint;
        logic                mh;
        logic [HC_W-1:0]     q;
        logic [HIGH_W-1:0]   p2r_hi;
        logic [LOW_W-1:0]    p2r_lo;
    } t_s2;

    // payload after stage 4
    typedef struct packed {
        t_mode               mode;
        logic                hint;
        logic                mh;
        logic [HC_W-1:0]     hc;
        logic [LOW_W-1:0]    dlow;
        logic [HIGH_W-1:0]   p2r_hi;
        logic [LOW_W-1:0]    p2r_lo;
    } t_s4;

endpackage

// ----- src/lcr_pipe_ctl.sv -----
// valid chain and stage load enables of the five-stage pipeline
module lcr_pipe_ctl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output lcr_pkg::t_pipe_ctl o_ctl,
    output logic               o_out_valid,
    input  logic               i_out_ready
);

    logic [lcr_pkg::N_STAGES-1:0] r_vld;
    logic [lcr_pkg::N_STAGES-1:0] n_vld;
    logic [lcr_pkg::N_STAGES-1:0] can_load;

    // a stage may load when it is empty or its content moves on
    always_comb begin
        can_load[lcr_pkg::N_STAGES-1] = !r_vld[lcr_pkg::N_STAGES-1] || i_out_ready;
        for (int k = lcr_pkg::N_STAGES - 2; k >= 0; k--) begin
            can_load[k] = !r_vld[k] || can_load[k+1];
        end
    end

    always_comb begin
        n_vld[0] = can_load[0] ? i_in_valid : r_vld[0];
        for (int k = 1; k < lcr_pkg::N_STAGES; k++) begin
            if (can_load[k]) begin
                n_vld[k] = r_vld[k-1];
            end else begin
                n_vld[k] = r_vld[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_ctl.en    = can_load;
    assign o_in_ready  = can_load[0];
    assign o_out_valid = r_vld[lcr_pkg::N_STAGES-1];

endmodule

// ----- src/lcr_front.sv -----
// stages 1 and 2: power2round, make hint compare, reciprocal multiply
module lcr_front #(
    parameter int DROP_BITS = lcr_pkg::DROP_BITS_DEF
) (
    input  logic                              i_clk,
    input  lcr_pkg::t_pipe_ctl                i_ctl,
    input  lcr_pkg::t_mode                    i_mode,
    input  logic [lcr_pkg::COEFF_W-1:0]       i_coeff,
    input  logic signed [lcr_pkg::LIN_W-1:0]  i_low_in,
    input  logic [lcr_pkg::HIN_W-1:0]         i_high_in,
    input  logic                              i_hint_in,
    output lcr_pkg::t_s2                      o_s2
);

    localparam int SUM_W  = lcr_pkg::COEFF_W + 1;
    localparam int P2R_HW = SUM_W - DROP_BITS;
    localparam logic [SUM_W-1:0] P2R_BIAS = SUM_W'((1 << (DROP_BITS - 1)) - 1);
    localparam logic signed [lcr_pkg::LIN_W-1:0] G2_POS = lcr_pkg::LIN_W'(lcr_pkg::GAMMA2);
    localparam logic signed [lcr_pkg::LIN_W-1:0] G2_NEG = -G2_POS;

    // stage 1
    lcr_pkg::t_mode               r_mode;
    logic [lcr_pkg::COEFF_W-1:0]  r_coeff;
    logic                         r_hint;
    logic                         r_mh;
    logic [lcr_pkg::T_W-1:0]      r_t;
    logic [P2R_HW-1:0]            r_ph;

    logic [SUM_W-1:0]             n_psum;
    logic [SUM_W-1:0]             n_rsum;
    logic                         n_mh;

    // stage 2
    lcr_pkg::t_s2                 r_s2;
    lcr_pkg::t_s2                 n_s2;
    logic [lcr_pkg::PROD_W-1:0]   prod;
    logic [SUM_W-1:0]             h_ext;
    logic [SUM_W-1:0]             h_shl;
    logic [SUM_W:0]               p2r_lo;

    always_comb begin
        n_psum = {1'b0, i_coeff} + P2R_BIAS;
        n_rsum = {1'b0, i_coeff} + SUM_W'(lcr_pkg::RND_BIAS);
        n_mh   = (i_low_in > G2_POS) || (i_low_in < G2_NEG) ||
                 ((i_low_in == G2_NEG) && (i_high_in != '0));
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[0]) begin
            r_mode  <= i_mode;
            r_coeff <= i_coeff;
            r_hint  <= i_hint_in;
            r_mh    <= n_mh;
            r_t     <= lcr_pkg::T_W'(n_rsum >> lcr_pkg::RND_SHIFT);
            r_ph    <= P2R_HW'(n_psum >> DROP_BITS);
        end
    end

    // quotient estimate by reciprocal, power2round low part
    always_comb begin
        prod   = lcr_pkg::PROD_W'(r_t) * lcr_pkg::PROD_W'(lcr_pkg::MUL_RECIP)
               + lcr_pkg::PROD_W'(1 << (lcr_pkg::RECIP_SHIFT - 1));
        h_ext  = SUM_W'(r_ph);
        h_shl  = h_ext << DROP_BITS;
        p2r_lo = {2'b00, r_coeff} - {1'b0, h_shl};

        n_s2.mode   = r_mode;
        n_s2.coeff  = r_coeff;
        n_s2.hint   = r_hint;
        n_s2.mh     = r_mh;
        n_s2.q      = prod[lcr_pkg::RECIP_SHIFT +: lcr_pkg::HC_W];
        n_s2.p2r_hi = h_ext[lcr_pkg::HIGH_W-1:0];
        n_s2.p2r_lo = p2r_lo[lcr_pkg::LOW_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[1]) begin
            r_s2 <= n_s2;
        end
    end

    assign o_s2 = r_s2;

endmodule

// ----- src/lcr_split.sv -----
// stages 3 and 4: clamp high, multiply by alpha, centered remainder
module lcr_split (
    input  logic               i_clk,
    input  lcr_pkg::t_pipe_ctl i_ctl,
    input  lcr_pkg::t_s2       i_s2,
    output lcr_pkg::t_s4       o_s4
);

    localparam int L_W = lcr_pkg::COEFF_W + 2;
    localparam logic [lcr_pkg::HC_W-1:0] HMAX = lcr_pkg::HC_W'(lcr_pkg::HIGH_MAX);
    localparam logic signed [L_W-1:0] HALF_Q_S = L_W'(lcr_pkg::HALF_Q);
    localparam logic signed [L_W-1:0] Q_S      = L_W'(lcr_pkg::Q_MOD);

    // stage 3
    lcr_pkg::t_s2                 r_s3;
    logic [lcr_pkg::HC_W-1:0]     r_hc;
    logic [lcr_pkg::COEFF_W-1:0]  r_mul;
    logic [lcr_pkg::HC_W-1:0]     n_hc;

    // stage 4
    lcr_pkg::t_s4                 r_s4;
    lcr_pkg::t_s4                 n_s4;
    logic signed [L_W-1:0]        rem;
    logic signed [L_W-1:0]        rem_c;

    // a quotient of 44 wraps to 0
    assign n_hc = (i_s2.q > HMAX) ? '0 : i_s2.q;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[2]) begin
            r_s3  <= i_s2;
            r_hc  <= n_hc;
            r_mul <= lcr_pkg::COEFF_W'(n_hc) * lcr_pkg::COEFF_W'(lcr_pkg::ALPHA);
        end
    end

    always_comb begin
        rem   = $signed({2'b00, r_s3.coeff}) - $signed({2'b00, r_mul});
        // upper half folds down by q
        rem_c = (rem > HALF_Q_S) ? rem - Q_S : rem;

        n_s4.mode   = r_s3.mode;
        n_s4.hint   = r_s3.hint;
        n_s4.mh     = r_s3.mh;
        n_s4.hc     = r_hc;
        n_s4.dlow   = rem_c[lcr_pkg::LOW_W-1:0];
        n_s4.p2r_hi = r_s3.p2r_hi;
        n_s4.p2r_lo = r_s3.p2r_lo;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[3]) begin
            r_s4 <= n_s4;
        end
    end

    assign o_s4 = r_s4;

endmodule

// ----- src/lcr_finish.sv -----
// stage 5: hint correction modulo 44 and per-mode result select
module lcr_finish (
    input  logic                              i_clk,
    input  lcr_pkg::t_pipe_ctl                i_ctl,
    input  lcr_pkg::t_s4                      i_s4,
    output logic [lcr_pkg::HIGH_W-1:0]        o_high_part,
    output logic signed [lcr_pkg::LOW_W-1:0]  o_low_part,
    output logic                              o_hint_out
);

    localparam logic [lcr_pkg::HC_W-1:0] HMAX = lcr_pkg::HC_W'(lcr_pkg::HIGH_MAX);
    localparam logic [lcr_pkg::HC_W-1:0] ONE  = lcr_pkg::HC_W'(1);

    logic [lcr_pkg::HIGH_W-1:0] r_high;
    logic [lcr_pkg::LOW_W-1:0]  r_low;
    logic                       r_hint;
    logic [lcr_pkg::HIGH_W-1:0] n_high;
    logic [lcr_pkg::LOW_W-1:0]  n_low;
    logic                       n_hint;
    logic                       low_pos;
    logic [lcr_pkg::HC_W-1:0]   adj;

    always_comb begin
        low_pos = !i_s4.dlow[lcr_pkg::LOW_W-1] && (i_s4.dlow != '0);
        if (!i_s4.hint) begin
            adj = i_s4.hc;
        end else if (low_pos) begin
            adj = (i_s4.hc == HMAX) ? '0 : i_s4.hc + ONE;
        end else begin
            adj = (i_s4.hc == '0) ? HMAX : i_s4.hc - ONE;
        end

        unique case (i_s4.mode)
            lcr_pkg::MODE_P2R: begin
                n_high = i_s4.p2r_hi;
                n_low  = i_s4.p2r_lo;
                n_hint = 1'b0;
            end
            lcr_pkg::MODE_DECOMPOSE: begin
                n_high = lcr_pkg::HIGH_W'(i_s4.hc);
                n_low  = i_s4.dlow;
                n_hint = 1'b0;
            end
            lcr_pkg::MODE_MAKE_HINT: begin
                n_high = '0;
                n_low  = '0;
                n_hint = i_s4.mh;
            end
            lcr_pkg::MODE_USE_HINT: begin
                n_high = lcr_pkg::HIGH_W'(adj);
                n_low  = '0;
                n_hint = 1'b0;
            end
            default: begin
                n_high = '0;
                n_low  = '0;
                n_hint = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[4]) begin
            r_high <= n_high;
            r_low  <= n_low;
            r_hint <= n_hint;
        end
    end

    assign o_high_part = r_high;
    assign o_low_part  = $signed(r_low);
    assign o_hint_out  = r_hint;

endmodule

// ----- src/lattice_coeff_rounding_unit.sv -----
// top level of the lattice coefficient rounding unit
//
// Rounds one coefficient per request for the lattice signature scheme
// (q = 8380417, gamma2 = (q-1)/88): the request's tuser picks power2round,
// decompose, make hint or use hint, and every request yields exactly one
// result request. The unit is a five-stage pipeline that accepts a new
// request every cycle unless the result side stalls with every stage
// full; a request passes through the stage 1 to stage 5 registers in
// order. The pipeline follows the divide-by-alpha path (reciprocal
// multiply, clamp and alpha multiply, subtract and fold, hint correction),
// with one register after each multiply. Backpressure on the result side
// holds a full stage unless a later stage is empty; empty stages fill, so
// bubbles are squeezed out and nothing is lost or repeated. No configuration,
// no state between requests, and reset only clears the valid bits.
module lattice_coeff_rounding_unit #(
    parameter int DROP_BITS = lcr_pkg::DROP_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    // request side
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // coeff[22:0], low_in[46:23], high_in[52:47], hint_in[53], zero pad[55:54]
    input  logic [lcr_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,
    // mode[1:0]
    input  logic [1:0]                      i_s_axis_tuser,

    // result side
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // high_part[9:0], low_part[27:10], hint_out[28], zero pad[31:29]
    output logic [lcr_pkg::M_TDATA_W-1:0]   o_m_axis_tdata
);

    lcr_pkg::t_pipe_ctl                   ctl;
    lcr_pkg::t_s2                         s2;
    lcr_pkg::t_s4                         s4;

    // unpacked request fields
    lcr_pkg::t_mode                       in_mode;
    logic [lcr_pkg::COEFF_W-1:0]          in_coeff;
    logic signed [lcr_pkg::LIN_W-1:0]     in_low;
    logic [lcr_pkg::HIN_W-1:0]            in_high;
    logic                                 in_hint;

    // result fields
    logic [lcr_pkg::HIGH_W-1:0]           out_high;
    logic signed [lcr_pkg::LOW_W-1:0]     out_low;
    logic                                 out_hint;

    assign in_mode  = lcr_pkg::t_mode'(i_s_axis_tuser);
    assign in_coeff = i_s_axis_tdata[22:0];
    assign in_low   = $signed(i_s_axis_tdata[46:23]);
    assign in_high  = i_s_axis_tdata[52:47];
    assign in_hint  = i_s_axis_tdata[53];

    // valid chain; stage k loads when empty or when its content moves on
    lcr_pipe_ctl u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_ctl       (ctl),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready)
    );

    // stages 1-2: power2round, make hint, quotient estimate
    lcr_front #(
        .DROP_BITS (DROP_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_ctl     (ctl),
        .i_mode    (in_mode),
        .i_coeff   (in_coeff),
        .i_low_in  (in_low),
        .i_high_in (in_high),
        .i_hint_in (in_hint),
        .o_s2      (s2)
    );

    // stages 3-4: high clamp, alpha product, centered low
    lcr_split u_split (
        .i_clk (i_clk),
        .i_ctl (ctl),
        .i_s2  (s2),
        .o_s4  (s4)
    );

    // stage 5: hint correction and result register
    lcr_finish u_finish (
        .i_clk       (i_clk),
        .i_ctl       (ctl),
        .i_s4        (s4),
        .o_high_part (out_high),
        .o_low_part  (out_low),
        .o_hint_out  (out_hint)
    );

    assign o_m_axis_tdata = {3'b000, out_hint, out_low, out_high};

endmodule

// ----- src/lcr_checker.sv -----
// port-level checks for the rounding unit and its bind
module lcr_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tready,
    input  logic                          i_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    input  logic [lcr_pkg::M_TDATA_W-1:0] i_m_axis_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && !i_m_axis_tready |=>
            i_m_axis_tvalid && $stable(i_m_axis_tdata))
        else $error("stalled result changed");

    // reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_axis_tvalid)
        else $error("result valid right after reset");

    // a draining output lets a request in
    a_flow: assert property (@(posedge i_clk)
        i_m_axis_tready |-> i_s_axis_tready)
        else $error("request stalled while output drains");

    // a make hint result carries no high or low part
    a_hint_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && i_m_axis_tdata[28] |->
            (i_m_axis_tdata[27:0] == 28'd0))
        else $error("hint result with nonzero high or low");

endmodule

bind lattice_coeff_rounding_unit lcr_checker u_lcr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tready (o_s_axis_tready),
    .i_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .i_m_axis_tdata  (o_m_axis_tdata)
);
